/* src/swtq_pkg.sv */
// Package for the sorted wakeup timer queue.
// Holds sizes, beat structs, status codes and the slot type shared by the cells and the top level.
// No dependencies.
package swtq_pkg;

	localparam int QUEUE_DEPTH  = 16;
	localparam int TASK_ID_BITS = 8;
	localparam int ID_W         = 8;
	localparam int TIME_W       = 64;
	// Only bits that can ever be nonzero are stored.
	localparam int TASK_W       = (TASK_ID_BITS < ID_W) ? TASK_ID_BITS : ID_W;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_EXPIRE = 1'b1;

	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_FULL     = 2'd1,
		ST_WOKEN    = 2'd2,
		ST_NONE_DUE = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INSERT,
		OP_POP
	} cell_op_t;

	typedef enum logic {
		S_IDLE,
		S_BUSY
	} fsm_t;

	typedef struct packed {
		logic              kind;
		logic [ID_W-1:0]   task_id;
		logic [TIME_W-1:0] time_value;
	} in_beat_t;

	typedef struct packed {
		logic [ID_W-1:0] woken_id;
		status_t         status;
		logic            last;
	} out_beat_t;

	typedef struct packed {
		logic              valid;
		logic [TIME_W-1:0] wake;
		logic [TASK_W-1:0] task_id;
	} slot_t;

endpackage

/* src/sorted_wakeup_timer_queue.sv */
// Sorted wakeup timer queue, top level.
// Depends on swtq_pkg and instantiates a chain of swtq_cell slots.

// The queue holds up to QUEUE_DEPTH sleeping tasks in a chain of cells kept in
// ascending wake-time order, the head in cell zero. An input beat is taken
// only while the controller is idle; it is registered and then worked once
// the output register can take a result. An insert is worked in one step:
// every cell compares its wake time against the new time in parallel and
// either keeps its entry, takes the new one, or takes its left neighbor's, so
// entries with an equal time stay first in, first out. An insert into a full
// queue is dropped and answered with a full status. An expire pops the head
// once per cycle while it is due and the output register can take a beat, and
// the last woken beat carries the last flag. All results leave through a
// single output register; a new input beat is taken while a finished result
// still waits there, and the controller stalls only when it needs to place a
// result and the register is still full. There is no clearing pass: the
// per-cell valid bits reset at once.
module sorted_wakeup_timer_queue
	import swtq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_beat_t  in_beat,
	output logic      out_valid,
	input  logic      out_ready,
	output out_beat_t out_beat
);

	fsm_t      state_q, state_d;
	in_beat_t  item_q;
	out_beat_t out_q, out_d;
	logic      out_valid_q, out_valid_d;
	cell_op_t  op;

	slot_t             slots [QUEUE_DEPTH];
	logic              les   [QUEUE_DEPTH];
	logic [TASK_W-1:0] new_task;
	logic              step;

	assign new_task = item_q.task_id[TASK_W-1:0];

	// The chain. Cell zero sees an always-due left neighbor so that it takes
	// the new entry when its own is later; the last cell sees an empty right
	// neighbor so that a pop leaves it empty.
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		slot_t prev_s, next_s;
		logic  prev_le_s;

		if (i == 0) begin : g_head
			assign prev_s    = '{valid: 1'b1, wake: '0, task_id: '0};
			assign prev_le_s = 1'b1;
		end else begin : g_body
			assign prev_s    = slots[i-1];
			assign prev_le_s = les[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign next_s = '{valid: 1'b0, wake: '0, task_id: '0};
		end else begin : g_mid
			assign next_s = slots[i+1];
		end

		swtq_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.op        (op),
			.key       (item_q.time_value),
			.new_task  (new_task),
			.prev_slot (prev_s),
			.prev_le   (prev_le_s),
			.next_slot (next_s),
			.slot      (slots[i]),
			.le        (les[i])
		);
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_beat  = out_q;

	// The held item advances only when the output register can take a beat.
	assign step = (state_q == S_BUSY) && (!out_valid_q || out_ready);

	always_comb begin
		state_d     = state_q;
		op          = OP_HOLD;
		out_d       = out_q;
		out_valid_d = out_valid_q && !out_ready;

		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_BUSY;
				end
			end
			S_BUSY: begin
				if (step) begin
					out_valid_d    = 1'b1;
					out_d.woken_id = '0;
					out_d.last     = 1'b1;
					if (item_q.kind == KIND_INSERT) begin
						state_d = S_IDLE;
						if (slots[QUEUE_DEPTH-1].valid) begin
							out_d.status = ST_FULL;
						end else begin
							op           = OP_INSERT;
							out_d.status = ST_INSERTED;
						end
					end else if (!les[0]) begin
						// Nothing at the head is due, including an empty queue.
						state_d      = S_IDLE;
						out_d.status = ST_NONE_DUE;
					end else begin
						// Pop the head; the run ends when the next entry is not due.
						op             = OP_POP;
						out_d.status   = ST_WOKEN;
						out_d.woken_id = ID_W'(slots[0].task_id);
						out_d.last     = !les[1];
						if (!les[1]) begin
							state_d = S_IDLE;
						end
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_q <= in_beat;
		end
		out_q <= out_d;
	end

endmodule

/* src/swtq_cell.sv */
// One slot of the sorted queue chain.
// Depends on swtq_pkg for the slot type and the cell operation codes.
module swtq_cell
	import swtq_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cell_op_t          op,
	input  logic [TIME_W-1:0] key,
	input  logic [TASK_W-1:0] new_task,
	input  slot_t             prev_slot,
	input  logic              prev_le,
	input  slot_t             next_slot,
	output slot_t             slot,
	output logic              le
);

	logic              valid_q;
	logic [TIME_W-1:0] wake_q;
	logic [TASK_W-1:0] task_q;
	slot_t             slot_q;
	slot_t             slot_d;

	assign slot_q = '{valid: valid_q, wake: wake_q, task_id: task_q};

	// This entry is due at, or sorts before, the broadcast key.
	assign le   = valid_q && (wake_q <= key);
	assign slot = slot_q;

	always_comb begin
		slot_d = slot_q;
		case (op)
			OP_INSERT: begin
				if (!le) begin
					if (prev_le) begin
						slot_d.valid   = 1'b1;
						slot_d.wake    = key;
						slot_d.task_id = new_task;
					end else begin
						slot_d = prev_slot;
					end
				end
			end
			OP_POP: begin
				slot_d = next_slot;
			end
			default: begin
				slot_d = slot_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= slot_d.valid;
		end
	end

	always_ff @(posedge clk) begin
		wake_q <= slot_d.wake;
		task_q <= slot_d.task_id;
	end

endmodule
